// ----- rtl/core/sobem_pkg.sv -----
package sobem_pkg;

    // pixel and field widths
    localparam int PIX_W          = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 12;
    localparam int THRESHOLD_W    = 8;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    localparam logic [FRAME_WIDTH_W-1:0]  RESET_FRAME_WIDTH    = 11'd600;
    localparam logic [FRAME_HEIGHT_W-1:0] RESET_FRAME_HEIGHT   = 12'd600;
    localparam logic [THRESHOLD_W-1:0]    RESET_EDGE_THRESHOLD = 8'd100;

    // smallest frame side that the window logic works with
    localparam int MIN_FRAME_DIM = 3;

    // input word opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // gradient magnitude arithmetic
    localparam int MAG_W  = 10;              // |gx|, |gy| up to 4 * 255
    localparam int SQR_W  = 2 * MAG_W;       // one square
    localparam int SUM_W  = SQR_W + 1;       // gx^2 + gy^2
    localparam int ROOT_W = 2 * PIX_W;       // radicand range before saturation

    localparam int QUEUE_DEPTH = 4;

    // one job handed from the front end to the magnitude unit
    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic [PIX_W-1:0] grey;
        logic             last;
    } t_sobem_job;

endpackage

// ----- rtl/core/sobem_front.sv -----
module sobem_front #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_opcode,
    input  logic [sobem_pkg::PIX_W-1:0]         i_pixel_value,
    input  logic [sobem_pkg::FRAME_WIDTH_W-1:0] i_frame_width,
    input  logic [sobem_pkg::FRAME_HEIGHT_W-1:0] i_frame_height,
    input  logic                                i_queue_full,
    output logic                                o_push,
    output sobem_pkg::t_sobem_job               o_job
);
    import sobem_pkg::*;

    localparam int AW = $clog2(MAX_LINE_WIDTH);
    localparam int WW = $clog2(MAX_LINE_WIDTH + 1);
    localparam int EW = (WW > FRAME_WIDTH_W) ? WW : FRAME_WIDTH_W;

    logic [EW-1:0]             w_ext;
    logic [WW-1:0]             eff_w;
    logic [FRAME_HEIGHT_W-1:0] eff_h;

    logic [AW-1:0]             r_col, n_col;
    logic [FRAME_HEIGHT_W-1:0] r_row, n_row;
    logic [WW-1:0]             r_flush, n_flush;

    logic                      accept;
    logic                      new_frame;
    logic [AW-1:0]             col_c;
    logic [FRAME_HEIGHT_W-1:0] row_c;
    logic                      push_req;
    logic                      s0_emit;
    logic                      s0_int;
    logic                      s0_last;
    logic [AW-1:0]             s0_addr;
    logic [PIX_W-1:0]          s0_pix;

    logic                      r_s1_valid;
    logic                      r_s1_emit;
    logic                      r_s1_int;
    logic                      r_s1_last;
    logic [AW-1:0]             r_s1_addr;
    logic [PIX_W-1:0]          r_s1_pix;
    logic [2*PIX_W-1:0]        r_rd;
    logic                      commit;

    logic [2*PIX_W-1:0]        r_line_mem [0:MAX_LINE_WIDTH-1];

    logic [PIX_W-1:0]          r_win [0:2][0:2];
    logic [PIX_W-1:0]          n_win [0:2][0:2];
    logic [PIX_W-1:0]          top;
    logic [PIX_W-1:0]          mid;
    logic [MAG_W-1:0]          gx_p, gx_n, gy_p, gy_n;
    logic [MAG_W-1:0]          ax, ay;

    // clamp the frame size registers
    always_comb begin
        w_ext = EW'(i_frame_width);
        if (w_ext < EW'(MIN_FRAME_DIM)) begin
            w_ext = EW'(MIN_FRAME_DIM);
        end else if (w_ext > EW'(MAX_LINE_WIDTH)) begin
            w_ext = EW'(MAX_LINE_WIDTH);
        end
        eff_w = WW'(w_ext);
    end

    assign eff_h = (i_frame_height < FRAME_HEIGHT_W'(MIN_FRAME_DIM)) ?
                   FRAME_HEIGHT_W'(MIN_FRAME_DIM) : i_frame_height;

    // one word in flight: the line store read completes before the next issue
    assign o_stall   = r_s1_valid || !i_rst_n;
    assign accept    = i_valid && !o_stall;
    assign new_frame = (r_row >= eff_h);
    assign row_c     = new_frame ? '0 : r_row;
    assign col_c     = new_frame ? '0 : r_col;

    // classify the word, pick the line store column and advance the raster
    always_comb begin
        push_req = 1'b0;
        s0_emit  = 1'b0;
        s0_int   = 1'b0;
        s0_last  = 1'b0;
        s0_addr  = col_c;
        s0_pix   = i_pixel_value;
        n_col    = r_col;
        n_row    = r_row;
        n_flush  = r_flush;
        if (accept) begin
            if (i_opcode == OP_PIXEL) begin
                push_req = 1'b1;
                s0_emit  = (row_c >= FRAME_HEIGHT_W'(2)) ||
                           ((row_c == FRAME_HEIGHT_W'(1)) && (col_c != '0));
                s0_int   = (row_c >= FRAME_HEIGHT_W'(2)) && (row_c < eff_h) &&
                           (col_c >= AW'(2)) && (WW'(col_c) < eff_w);
                n_flush  = new_frame ? '0 : r_flush;
                if ((WW'(col_c) + WW'(1)) >= eff_w) begin
                    n_col = '0;
                    n_row = row_c + FRAME_HEIGHT_W'(1);
                end else begin
                    n_col = col_c + AW'(1);
                    n_row = row_c;
                end
            end else if (new_frame) begin
                // drain the tail with black pixels
                push_req = 1'b1;
                s0_emit  = 1'b1;
                s0_pix   = '0;
                if (r_flush < eff_w) begin
                    s0_addr = AW'(r_flush);
                    n_flush = r_flush + WW'(1);
                end else begin
                    s0_addr = '0;
                    s0_last = 1'b1;
                    n_row   = '0;
                    n_col   = '0;
                    n_flush = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_flush <= n_flush;
        end
    end

    // second step: read data is back, window shifts and line store is written
    assign commit = r_s1_valid && (!r_s1_emit || !i_queue_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (push_req) begin
            r_s1_valid <= 1'b1;
        end else if (commit) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_req) begin
            r_s1_emit <= s0_emit;
            r_s1_int  <= s0_int;
            r_s1_last <= s0_last;
            r_s1_addr <= s0_addr;
            r_s1_pix  <= s0_pix;
        end
    end

    // line stores: upper in the high byte, middle in the low byte
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_line_mem[r_s1_addr] <= {mid, r_s1_pix};
        end
        if (push_req) begin
            r_rd <= r_line_mem[s0_addr];
        end
    end

    assign top = r_rd[2*PIX_W-1:PIX_W];
    assign mid = r_rd[PIX_W-1:0];

    // 3x3 window shift
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = top;
        n_win[1][2] = mid;
        n_win[2][2] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (commit) begin
            r_win <= n_win;
        end
    end

    // Sobel sums on the shifted window, taken as |positive - negative|
    assign gx_p = MAG_W'(n_win[0][2]) + (MAG_W'(n_win[1][2]) << 1) + MAG_W'(n_win[2][2]);
    assign gx_n = MAG_W'(n_win[0][0]) + (MAG_W'(n_win[1][0]) << 1) + MAG_W'(n_win[2][0]);
    assign gy_p = MAG_W'(n_win[2][0]) + (MAG_W'(n_win[2][1]) << 1) + MAG_W'(n_win[2][2]);
    assign gy_n = MAG_W'(n_win[0][0]) + (MAG_W'(n_win[0][1]) << 1) + MAG_W'(n_win[0][2]);
    assign ax   = (gx_p >= gx_n) ? (gx_p - gx_n) : (gx_n - gx_p);
    assign ay   = (gy_p >= gy_n) ? (gy_p - gy_n) : (gy_n - gy_p);

    // border positions go out with zero gradient
    assign o_push     = commit && r_s1_emit;
    assign o_job.ax   = r_s1_int ? ax : '0;
    assign o_job.ay   = r_s1_int ? ay : '0;
    assign o_job.grey = n_win[1][1];
    assign o_job.last = r_s1_last;

endmodule

// ----- rtl/core/sobem_queue.sv -----
module sobem_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sobem_pkg::t_sobem_job i_job,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_not_empty,
    output sobem_pkg::t_sobem_job o_job
);
    import sobem_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_sobem_job    r_slot [0:QUEUE_DEPTH-1];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full      = (r_count == CW'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_job       = r_slot[r_rd_ptr];

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/core/sobem_back.sv -----
module sobem_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_job_valid,
    output logic                              o_pop,
    input  sobem_pkg::t_sobem_job             i_job,
    input  logic [sobem_pkg::THRESHOLD_W-1:0] i_edge_threshold,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sobem_pkg::PIX_W-1:0]       o_edge_value,
    output logic [sobem_pkg::PIX_W-1:0]       o_grey_value,
    output logic [sobem_pkg::PIX_W-1:0]       o_overlay_red,
    output logic [sobem_pkg::PIX_W-1:0]       o_overlay_green,
    output logic [sobem_pkg::PIX_W-1:0]       o_overlay_blue,
    output logic                              o_is_edge,
    output logic                              o_frame_last
);
    import sobem_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_SUM    = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [MAG_W-1:0]  r_ax, r_ay;
    logic [PIX_W-1:0]  r_grey;
    logic              r_last;
    logic [SQR_W-1:0]  r_sq_x, r_sq_y;
    logic [SUM_W-1:0]  sum;
    logic              r_sat;
    logic [ROOT_W-1:0] r_rem, r_res, r_bit;
    logic [ROOT_W:0]   trial;
    logic              out_free;
    logic              load_out;
    logic [PIX_W-1:0]  edge_val;
    logic              edge_hit;

    logic              r_o_valid;
    logic [PIX_W-1:0]  r_edge, r_grey_out, r_red, r_green, r_blue;
    logic              r_is_edge, r_frame_last;

    assign out_free = !r_o_valid || !i_stall;
    assign load_out = (r_state == ST_DONE) && out_free;
    assign o_pop    = (r_state == ST_IDLE) && i_job_valid;

    // sequencer: square, add, eight root steps, hand off
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_job_valid) n_state = ST_SQUARE;
            ST_SQUARE: n_state = ST_SUM;
            ST_SUM:    n_state = ST_ROOT;
            ST_ROOT:   if (r_bit[0]) n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign sum   = SUM_W'(r_sq_x) + SUM_W'(r_sq_y);
    assign trial = {1'b0, r_res} + {1'b0, r_bit};

    // magnitude datapath, one radicand digit pair per root step
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    r_ax   <= i_job.ax;
                    r_ay   <= i_job.ay;
                    r_grey <= i_job.grey;
                    r_last <= i_job.last;
                end
            end
            ST_SQUARE: begin
                r_sq_x <= SQR_W'(r_ax * r_ax);
                r_sq_y <= SQR_W'(r_ay * r_ay);
            end
            ST_SUM: begin
                r_sat <= |sum[SUM_W-1:ROOT_W];
                r_rem <= sum[ROOT_W-1:0];
                r_res <= '0;
                r_bit <= ROOT_W'(1) << (ROOT_W - 2);
            end
            ST_ROOT: begin
                if ({1'b0, r_rem} >= trial) begin
                    r_rem <= r_rem - trial[ROOT_W-1:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: begin
            end
        endcase
    end

    // saturate and compare against the threshold
    assign edge_val = r_sat ? {PIX_W{1'b1}} : r_res[PIX_W-1:0];
    assign edge_hit = (edge_val > i_edge_threshold);

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_edge       <= edge_val;
            r_grey_out   <= r_grey;
            r_red        <= edge_hit ? {PIX_W{1'b1}} : r_grey;
            r_green      <= edge_hit ? '0 : r_grey;
            r_blue       <= edge_hit ? '0 : r_grey;
            r_is_edge    <= edge_hit;
            r_frame_last <= r_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_edge_value    = r_edge;
    assign o_grey_value    = r_grey_out;
    assign o_overlay_red   = r_red;
    assign o_overlay_green = r_green;
    assign o_overlay_blue  = r_blue;
    assign o_is_edge       = r_is_edge;
    assign o_frame_last    = r_frame_last;

endmodule

// ----- rtl/core/sobel_edge_magnitude_stream.sv -----
// Path: line store read, window and line store update, job queue, then the magnitude unit,
// whose eight-step square root iteration sets the result rate; it takes a new job only
// after handing the last to the output register. A new input word is taken once the last
// has passed the line store step; a flush word that is ignored holds nothing up.
// Reset (i_rst_n low, synchronous) clears counters, window, queue and
// configuration (width 600, height 600, threshold 100); line stores are not cleared.
module sobel_edge_magnitude_stream #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_opcode,
    input  logic [sobem_pkg::PIX_W-1:0]         i_pixel_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [sobem_pkg::PIX_W-1:0]         o_edge_value,
    output logic [sobem_pkg::PIX_W-1:0]         o_grey_value,
    output logic [sobem_pkg::PIX_W-1:0]         o_overlay_red,
    output logic [sobem_pkg::PIX_W-1:0]         o_overlay_green,
    output logic [sobem_pkg::PIX_W-1:0]         o_overlay_blue,
    output logic                                o_is_edge,
    output logic                                o_frame_last,
    input  logic                                i_cfg_wr_en,
    input  logic [sobem_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [sobem_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sobem_pkg::*;

    logic [FRAME_WIDTH_W-1:0]  r_frame_width;
    logic [FRAME_HEIGHT_W-1:0] r_frame_height;
    logic [THRESHOLD_W-1:0]    r_edge_threshold;

    logic       push;
    logic       queue_full;
    logic       job_valid;
    logic       pop;
    t_sobem_job push_job;
    t_sobem_job pop_job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= RESET_FRAME_WIDTH;
            r_frame_height   <= RESET_FRAME_HEIGHT;
            r_edge_threshold <= RESET_EDGE_THRESHOLD;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data[FRAME_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data[FRAME_HEIGHT_W-1:0];
                CFG_EDGE_THRESHOLD: r_edge_threshold <= i_cfg_data[THRESHOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // line stores, window and raster tracking
    sobem_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_pixel_value  (i_pixel_value),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_queue_full   (queue_full),
        .o_push         (push),
        .o_job          (push_job)
    );

    // job queue between the two halves
    sobem_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (push_job),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_not_empty (job_valid),
        .o_job       (pop_job)
    );

    // magnitude, threshold and overlay
    sobem_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (job_valid),
        .o_pop            (pop),
        .i_job            (pop_job),
        .i_edge_threshold (r_edge_threshold),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_edge_value     (o_edge_value),
        .o_grey_value     (o_grey_value),
        .o_overlay_red    (o_overlay_red),
        .o_overlay_green  (o_overlay_green),
        .o_overlay_blue   (o_overlay_blue),
        .o_is_edge        (o_is_edge),
        .o_frame_last     (o_frame_last)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import sobem_pkg::*;

    localparam int unsigned LINE_MAX      = 1024;
    localparam int unsigned RANDOM_WORDS  = 950;
    localparam int unsigned QUIET_TAIL    = 150;    // last words run with no idling
    localparam int unsigned WIDE_BUDGET   = 450;    // wide lines only while this much is left
    localparam int unsigned SETTLE_CYCLES = 20;     // result latency plus slack
    localparam int unsigned HOLD_CYCLES   = 300;    // long output hold-off
    localparam int unsigned CYCLE_LIMIT   = 500000;

    typedef enum {PX_NOISE, PX_BINARY, PX_FLAT, PX_SPIKES} t_px_style;

    // one output word: magnitude, grey and overlay for a position
    typedef struct {
        logic [PIX_W-1:0] mag;
        logic [PIX_W-1:0] grey;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             hit;
        logic             last;
    } t_overlay_px;

    // Sobel overlay predictor plus the queue of positions still owed by the block
    class t_sobel_overlay_board;
        bit [FRAME_WIDTH_W-1:0]  width_reg;
        bit [FRAME_HEIGHT_W-1:0] height_reg;
        bit [THRESHOLD_W-1:0]    thresh_reg;
        bit [PIX_W-1:0]          upper_line [LINE_MAX];
        bit [PIX_W-1:0]          middle_line[LINE_MAX];
        bit [PIX_W-1:0]          win[3][3];
        int unsigned             col, row, flushes;
        t_overlay_px             pending_px[$];
        int unsigned             words_taken, results_seen, mismatches;

        function new();
            width_reg  = RESET_FRAME_WIDTH;
            height_reg = RESET_FRAME_HEIGHT;
            thresh_reg = RESET_EDGE_THRESHOLD;
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (win[i, j]) win[i][j] = '0;
            col = 0;
            row = 0;
            flushes = 0;
            words_taken = 0;
            results_seen = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FRAME_WIDTH:    width_reg  = val[FRAME_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT:   height_reg = val[FRAME_HEIGHT_W-1:0];
                CFG_EDGE_THRESHOLD: thresh_reg = val[THRESHOLD_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned active_width();
            if (width_reg < MIN_FRAME_DIM) return MIN_FRAME_DIM;
            if (width_reg > LINE_MAX) return LINE_MAX;
            return width_reg;
        endfunction

        function int unsigned active_height();
            if (height_reg < MIN_FRAME_DIM) return MIN_FRAME_DIM;
            return height_reg;
        endfunction

        function int unsigned floor_root(int unsigned v);
            int unsigned r;
            int b;
            r = 0;
            for (b = 11; b >= 0; b--) begin
                if ((r | (32'd1 << b)) * (r | (32'd1 << b)) <= v) r = r | (32'd1 << b);
            end
            return r;
        endfunction

        // push one pixel at (r, c) through line stores and window, score the lagged spot
        function t_overlay_px shift_in(int unsigned r, int unsigned c, bit [PIX_W-1:0] pix,
                                       int unsigned w, int unsigned h, bit last);
            bit [PIX_W-1:0] top, mid;
            t_overlay_px    px;
            int             sx, sy;
            int unsigned    ax, ay, mag;
            top = '0;
            mid = '0;
            if (c < LINE_MAX) begin
                top = upper_line[c];
                mid = middle_line[c];
                upper_line[c]  = mid;
                middle_line[c] = pix;
            end
            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = pix;

            mag = 0;
            if (r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w) begin
                sx = int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2])
                   - int'(win[0][0]) - 2 * int'(win[1][0]) - int'(win[2][0]);
                sy = int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2])
                   - int'(win[0][0]) - 2 * int'(win[0][1]) - int'(win[0][2]);
                ax = (sx < 0) ? -sx : sx;
                ay = (sy < 0) ? -sy : sy;
                mag = floor_root(ax * ax + ay * ay);
                if (mag > 255) mag = 255;
            end
            px.mag   = mag[PIX_W-1:0];
            px.grey  = win[1][1];
            px.hit   = (mag > thresh_reg);
            px.red   = px.hit ? 8'hFF : px.grey;
            px.green = px.hit ? 8'h00 : px.grey;
            px.blue  = px.hit ? 8'h00 : px.grey;
            px.last  = last;
            return px;
        endfunction

        // note an accepted input word and queue the result it owes, if any
        function void take_word(logic op, logic [PIX_W-1:0] pix);
            int unsigned w, h, r, c;
            bit          emit;
            t_overlay_px px;
            w = active_width();
            h = active_height();
            words_taken++;
            if (op == OP_PIXEL) begin
                // a pixel once all lines are in opens a new frame
                if (row >= h) begin
                    row = 0;
                    col = 0;
                    flushes = 0;
                end
                r = row;
                c = col;
                emit = (r >= 2) || (r == 1 && c >= 1);
                px = shift_in(r, c, pix, w, h, 1'b0);
                if (c + 1 >= w) begin
                    col = 0;
                    row = r + 1;
                end else begin
                    col = c + 1;
                end
                if (emit) pending_px.push_back(px);
            end else if (row >= h) begin
                // drain: zero pixels along a virtual row, then the closing position
                if (flushes < w) begin
                    px = shift_in(h, flushes, '0, w, h, 1'b0);
                    flushes++;
                end else begin
                    px = shift_in(h + 1, 0, '0, w, h, 1'b1);
                    row = 0;
                    col = 0;
                    flushes = 0;
                end
                pending_px.push_back(px);
            end
        endfunction

        function void cmp_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        // check one accepted output word against the oldest owed position
        function void check_word(t_overlay_px got);
            t_overlay_px want;
            results_seen++;
            if (pending_px.size() == 0) begin
                mismatches++;
                $error("output word with nothing pending, edge_value %0d", got.mag);
                return;
            end
            want = pending_px.pop_front();
            cmp_field("edge_value",    want.mag,   got.mag);
            cmp_field("grey_value",    want.grey,  got.grey);
            cmp_field("overlay_red",   want.red,   got.red);
            cmp_field("overlay_green", want.green, got.green);
            cmp_field("overlay_blue",  want.blue,  got.blue);
            cmp_field("is_edge",       want.hit,   got.hit);
            cmp_field("frame_last",    want.last,  got.last);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic                   i_opcode;
    logic [PIX_W-1:0]       i_pixel_value;
    logic                   o_valid;
    logic                   i_stall;
    logic [PIX_W-1:0]       o_edge_value;
    logic [PIX_W-1:0]       o_grey_value;
    logic [PIX_W-1:0]       o_overlay_red;
    logic [PIX_W-1:0]       o_overlay_green;
    logic [PIX_W-1:0]       o_overlay_blue;
    logic                   o_is_edge;
    logic                   o_frame_last;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    t_sobel_overlay_board board;
    bit                   sender_gaps;
    bit                   stall_bursts;
    int                   hold_request;
    int unsigned          random_words;
    int unsigned          frames_sent;
    int unsigned          cycle_count;

    sobel_edge_magnitude_stream #(
        .MAX_LINE_WIDTH(LINE_MAX)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_pixel_value  (i_pixel_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_edge_value   (o_edge_value),
        .o_grey_value   (o_grey_value),
        .o_overlay_red  (o_overlay_red),
        .o_overlay_green(o_overlay_green),
        .o_overlay_blue (o_overlay_blue),
        .o_is_edge      (o_is_edge),
        .o_frame_last   (o_frame_last),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sobel_edge_magnitude_stream test failed");
            $finish;
        end
    end

    // sample both channels at the rising edge
    always @(posedge i_clk) begin : monitor
        t_overlay_px seen;
        if (i_rst_n) begin
            if (i_valid && !o_stall) board.take_word(i_opcode, i_pixel_value);
            if (o_valid && !i_stall) begin
                seen.mag   = o_edge_value;
                seen.grey  = o_grey_value;
                seen.red   = o_overlay_red;
                seen.green = o_overlay_green;
                seen.blue  = o_overlay_blue;
                seen.hit   = o_is_edge;
                seen.last  = o_frame_last;
                board.check_word(seen);
            end
        end
    end

    // receiver: short stall bursts, plus one long hold-off on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                i_stall <= 1'b1;
                repeat (hold_request) @(negedge i_clk);
                hold_request = 0;
                i_stall <= 1'b0;
            end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    function automatic bit [PIX_W-1:0] pick_pixel(t_px_style style);
        case (style)
            PX_NOISE:  return 8'($urandom_range(0, 255));
            PX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PX_FLAT:   return 8'($urandom_range(96, 160));
            default:   return ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 15));
        endcase
    endfunction

    // offer one word, maybe after a gap, and hold it until taken
    task automatic send_word(bit op, bit [PIX_W-1:0] pix);
        @(negedge i_clk);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_line(bit [23:0] px3);
        send_word(OP_PIXEL, px3[23:16]);
        send_word(OP_PIXEL, px3[15:8]);
        send_word(OP_PIXEL, px3[7:0]);
    endtask

    // go idle, wait for every owed word, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        board.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // one frame at the current size; the drain may be cut short by the next frame
    task automatic run_frame(t_px_style style, bit may_cut);
        int unsigned w, h, k, n_flush;
        w = board.active_width();
        h = board.active_height();
        for (k = 0; k < w * h; k++) begin
            if ($urandom_range(0, 39) == 0) send_word(OP_FLUSH, 8'($urandom_range(0, 255)));
            send_word(OP_PIXEL, pick_pixel(style));
        end
        n_flush = w + 1;
        if (may_cut && $urandom_range(0, 4) == 0) n_flush = $urandom_range(0, w);
        for (k = 0; k < n_flush; k++) send_word(OP_FLUSH, 8'($urandom_range(0, 255)));
        // stray flush once drained: ignored
        if (n_flush == w + 1 && $urandom_range(0, 5) == 0) send_word(OP_FLUSH, 8'hFF);
        random_words += w * h + n_flush;
        frames_sent++;
    endtask

    // height grows to the maximum mid-frame, then shrinks to at most the rows already in
    task automatic run_tall_frame();
        int unsigned w, k;
        w = board.active_width();
        cfg_write(CFG_FRAME_HEIGHT, 12'd3);
        for (k = 0; k < 2 * w; k++) send_word(OP_PIXEL, pick_pixel(PX_NOISE));
        settle();
        cfg_write(CFG_FRAME_HEIGHT, 12'd4095);
        for (k = 0; k < 2 * w; k++) send_word(OP_PIXEL, pick_pixel(PX_BINARY));
        settle();
        cfg_write(CFG_FRAME_HEIGHT, 12'($urandom_range(0, 4)));
        for (k = 0; k <= w; k++) send_word(OP_FLUSH, 8'($urandom_range(0, 255)));
        random_words += 5 * w + 1;
        frames_sent++;
    endtask

    initial begin
        int unsigned n_frames, w_cfg, h_cfg, t_cfg, budget, frame_px;
        bit          quiet, hold_done;
        board         = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_opcode      = OP_PIXEL;
        i_pixel_value = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_FRAME_WIDTH;
        i_cfg_data    = '0;
        sender_gaps   = 1'b0;
        stall_bursts  = 1'b0;
        hold_request  = 0;
        random_words  = 0;
        frames_sent   = 0;
        hold_done     = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: register extremes, a mid-line width shrink, early restart
        sender_gaps  = 1'b1;
        stall_bursts = 1'b1;
        cfg_write(CFG_FRAME_WIDTH, 12'd2047);
        cfg_write(CFG_FRAME_HEIGHT, 12'd0);
        cfg_write(CFG_EDGE_THRESHOLD, 12'd0);
        send_line(24'h00_00_FF);            // row 0 at a line of 1024
        send_word(OP_FLUSH, 8'hA5);         // flush inside a frame: ignored
        settle();
        cfg_write(CFG_FRAME_WIDTH, 12'd1);  // acts as 3, so column 3 closes row 0
        send_word(OP_PIXEL, 8'h00);
        send_line(24'h00_00_FF);
        send_line(24'hFF_FF_FF);            // saturated magnitude over threshold 0
        send_word(OP_FLUSH, 8'h00);
        send_word(OP_FLUSH, 8'hFF);
        send_line(24'hFF_FF_FF);            // pixel mid-drain opens the next frame
        settle();
        cfg_write(CFG_EDGE_THRESHOLD, 12'd255);
        send_line(24'h00_80_FF);
        send_line(24'h00_00_00);
        repeat (4) send_word(OP_FLUSH, 8'h5A);
        send_word(OP_FLUSH, 8'hC3);         // after the drain: ignored
        frames_sent = 2;

        // random phases: each starts idle with a fresh setting and ends fully drained
        while (random_words < RANDOM_WORDS) begin
            settle();
            budget = RANDOM_WORDS - random_words;
            case ($urandom_range(0, 5))
                0:       w_cfg = $urandom_range(0, 2);
                1:       w_cfg = (budget > WIDE_BUDGET) ? $urandom_range(16, 48)
                                                        : $urandom_range(3, 12);
                default: w_cfg = $urandom_range(3, 12);
            endcase
            h_cfg = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            case ($urandom_range(0, 3))
                0:       t_cfg = 0;
                1:       t_cfg = 255;
                default: t_cfg = $urandom_range(0, 255);
            endcase
            cfg_write(CFG_FRAME_WIDTH, 12'(w_cfg));
            cfg_write(CFG_FRAME_HEIGHT, 12'(h_cfg));
            cfg_write(CFG_EDGE_THRESHOLD, 12'(t_cfg));

            quiet        = (random_words + QUIET_TAIL >= RANDOM_WORDS);
            sender_gaps  = !quiet && ($urandom_range(0, 3) != 0);
            stall_bursts = !quiet && ($urandom_range(0, 3) != 0);
            if (!hold_done && random_words >= 200) begin
                hold_request = HOLD_CYCLES;
                hold_done    = 1'b1;
            end

            if ($urandom_range(0, 5) == 0) begin
                run_tall_frame();
            end else begin
                n_frames = $urandom_range(1, 3);
                // keep the last phases near the word budget
                frame_px = board.active_width() * board.active_height();
                while (n_frames > 1 && n_frames * frame_px > budget) n_frames--;
                for (int f = 0; f < n_frames; f++) begin
                    run_frame(t_px_style'($urandom_range(0, 3)), f + 1 < n_frames);
                end
            end
        end
        settle();

        $display("Checked %0d output words from %0d input words over %0d frames.",
                 board.results_seen, board.words_taken, frames_sent);
        $display("Register extremes, mid-frame size changes, cut drains, long hold-off: %0s.",
                 hold_done ? "all exercised" : "hold-off missing");
        if (board.mismatches == 0 && board.pending_px.size() == 0) begin
            $display("sobel_edge_magnitude_stream test passed");
        end else begin
            $display("sobel_edge_magnitude_stream test failed");
        end
        $finish;
    end

endmodule
